>>> rtl/gamepad_event_generator_top_assert.svh
// assertion macros for the gamepad event generator checker
// expects clk and rst_n in the scope where a macro is used
`ifndef GAMEPAD_EVENT_GENERATOR_TOP_ASSERT_SVH
`define GAMEPAD_EVENT_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define GEV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gev check failed");

// next-cycle implication, held off during reset
`define GEV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gev check failed");

`endif

>>> rtl/gev_pkg.sv
// shared types, constants and helpers for the gamepad event generator
// used by gev_ctrl, gev_dp and the top level; no dependencies
`default_nettype none

package gev_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int LVL_W = PTR_W + 1;
  localparam int CNT_W = (LVL_W > 6) ? LVL_W : 6;
  localparam int PADDR_W = 4;

  localparam logic [31:0] NEUTRAL_BIT = 32'h8000_0000;
  localparam logic [31:0] DPAD_UP     = 32'h0000_0010;
  localparam logic [31:0] DPAD_DOWN   = 32'h0000_0040;
  localparam logic [31:0] DPAD_LEFT   = 32'h0000_0080;
  localparam logic [31:0] DPAD_RIGHT  = 32'h0000_0020;
  localparam logic [7:0]  STICK_CENTER = 8'd128;

  localparam logic [6:0]  DEADZONE_RST = 7'd32;
  localparam logic [15:0] DELAY_RST    = 16'd400;
  localparam logic [15:0] PERIOD_RST   = 16'd100;

  localparam logic [3:0] ACT_UP = 4'd8;

  localparam logic [7:0][31:0] BUTTON_MASK = {
    32'h0010_0000, 32'h0000_0800, 32'h0000_0400, 32'h0000_0008,
    32'h0000_1000, 32'h0000_8000, 32'h0000_2000, 32'h0000_4000
  };

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_REPEAT = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DEADZONE = 2'd0,
    REG_DELAY    = 2'd1,
    REG_PERIOD   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BTN,
    ST_DREL,
    ST_DSET,
    ST_REP,
    ST_POP,
    ST_DONE
  } state_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic capture;
    logic btn_step;
    logic dir_rel;
    logic dir_set;
    logic rep_step;
    logic pop_step;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    cmd_t item_cmd;
    logic btn_last;
    logic dir_change;
    logic out_free;
  } sts_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gamepad_event_generator_top.sv
// an input passes decode; a pad sample then takes a step per button (one ring push per
// cycle), and a direction release and set when the direction changes; repeat check or
// pop takes one step, an unused command none; the result load waits for a free output
// register; one item at a time: in_ready returns in the cycle after the result loads
// rst_n is synchronous: clears pointers, held state, direction and the repeat deadline,
// restores config defaults; ring contents are not cleared and need no clearing pass
`default_nettype none

module gamepad_event_generator_top (
  input  wire                         clk,
  input  wire                         rst_n,
  // input channel
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [1:0]                  in_cmd,
  input  wire  [31:0]                 in_button_word,
  input  wire                         in_pad_connected,
  input  wire  [7:0]                  in_stick_x,
  input  wire  [7:0]                  in_stick_y,
  input  wire  [31:0]                 in_time_ms,
  // result channel
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_event_valid,
  output logic [3:0]                  out_event_action,
  output logic                        out_event_pressed,
  output logic [7:0]                  out_held_buttons,
  output logic                        out_direction_held,
  output logic [1:0]                  out_held_direction,
  output logic [5:0]                  out_queue_count,
  // config port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [gev_pkg::PADDR_W-1:0] paddr,
  input  wire  [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  gev_pkg::ctl_t ctl;
  gev_pkg::sts_t sts;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  gev_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  gev_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_button_word     (in_button_word),
    .in_pad_connected   (in_pad_connected),
    .in_stick_x         (in_stick_x),
    .in_stick_y         (in_stick_y),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_valid    (out_event_valid),
    .out_event_action   (out_event_action),
    .out_event_pressed  (out_event_pressed),
    .out_held_buttons   (out_held_buttons),
    .out_direction_held (out_direction_held),
    .out_held_direction (out_held_direction),
    .out_queue_count    (out_queue_count),
    .cfg_wr             (cfg_wr),
    .cfg_addr           (paddr),
    .cfg_wdata          (pwdata),
    .cfg_rdata          (prdata)
  );

endmodule

`default_nettype wire

>>> rtl/gev_ctrl.sv
// sequencing state machine for the gamepad event generator
// depends on gev_pkg; drives gev_dp through ctl_t, reads sts_t back
`default_nettype none

module gev_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  gev_pkg::sts_t    sts,
  output gev_pkg::ctl_t    ctl
);

  gev_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gev_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gev_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = gev_pkg::ST_DECODE;
        end
      end
      gev_pkg::ST_DECODE: begin
        case (sts.item_cmd)
          gev_pkg::CMD_SAMPLE: state_nxt = gev_pkg::ST_BTN;
          gev_pkg::CMD_REPEAT: state_nxt = gev_pkg::ST_REP;
          gev_pkg::CMD_POP:    state_nxt = gev_pkg::ST_POP;
          default:             state_nxt = gev_pkg::ST_DONE;
        endcase
      end
      gev_pkg::ST_BTN: begin
        ctl.btn_step = 1'b1;
        if (sts.btn_last) begin
          state_nxt = gev_pkg::ST_DREL;
        end
      end
      gev_pkg::ST_DREL: begin
        // release of the old direction, only if the direction moves
        if (sts.dir_change) begin
          ctl.dir_rel = 1'b1;
          state_nxt   = gev_pkg::ST_DSET;
        end else begin
          state_nxt = gev_pkg::ST_DONE;
        end
      end
      gev_pkg::ST_DSET: begin
        ctl.dir_set = 1'b1;
        state_nxt   = gev_pkg::ST_DONE;
      end
      gev_pkg::ST_REP: begin
        ctl.rep_step = 1'b1;
        state_nxt    = gev_pkg::ST_DONE;
      end
      gev_pkg::ST_POP: begin
        ctl.pop_step = 1'b1;
        state_nxt    = gev_pkg::ST_DONE;
      end
      gev_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = gev_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gev_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/gev_dp.sv
// datapath: config registers, item capture, event ring, direction and repeat logic
// depends on gev_pkg; commanded by gev_ctrl
`default_nettype none

module gev_dp (
  input  wire                           clk,
  input  wire                           rst_n,
  input  gev_pkg::ctl_t                 ctl,
  output gev_pkg::sts_t                 sts,
  // item fields
  input  wire  [1:0]                    in_cmd,
  input  wire  [31:0]                   in_button_word,
  input  wire                           in_pad_connected,
  input  wire  [7:0]                    in_stick_x,
  input  wire  [7:0]                    in_stick_y,
  input  wire  [31:0]                   in_time_ms,
  // result
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_event_valid,
  output logic [3:0]                    out_event_action,
  output logic                          out_event_pressed,
  output logic [7:0]                    out_held_buttons,
  output logic                          out_direction_held,
  output logic [1:0]                    out_held_direction,
  output logic [5:0]                    out_queue_count,
  // config
  input  wire                           cfg_wr,
  input  wire  [gev_pkg::PADDR_W-1:0]   cfg_addr,
  input  wire  [31:0]                   cfg_wdata,
  output logic [31:0]                   cfg_rdata
);

  // config registers
  logic [6:0]  deadzone_r;
  logic [15:0] delay_r;
  logic [15:0] period_r;

  // captured item
  gev_pkg::cmd_t cmd_r;
  logic [31:0]   word_r;
  logic          neutral_r;
  logic [7:0]    sx_r, sy_r;
  logic [31:0]   time_r;
  logic [2:0]    btn_idx_r;
  logic          pop_hit_r;

  // pad state
  logic [7:0]    latch_r;
  logic          dir_active_r;
  logic [1:0]    dir_code_r;
  logic [31:0]   deadline_r;

  // event ring
  logic [4:0]    ring [gev_pkg::QUEUE_DEPTH];
  logic [4:0]    mem_q_r;
  gev_pkg::ptr_t rd_ptr_r, wr_ptr_r;

  // result register
  logic          out_valid_r;

  logic [1:0]    reg_idx;
  logic          neutral_in;
  logic [7:0]    held;
  logic [7:0]    hs, vs, dz;
  logic          st_valid;
  logic [1:0]    st_code;
  logic          nd_valid;
  logic [1:0]    nd_code;
  logic          dir_change;
  logic [31:0]   due_diff;
  logic          rep_due;
  logic          push_en;
  logic [4:0]    push_entry;
  gev_pkg::ptr_t wr_next;
  logic [gev_pkg::LVL_W-1:0] lvl;
  logic [gev_pkg::CNT_W-1:0] lvl_ext;
  logic [5:0]    lvl_sat;

  assign reg_idx = cfg_addr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= gev_pkg::DEADZONE_RST;
      delay_r    <= gev_pkg::DELAY_RST;
      period_r   <= gev_pkg::PERIOD_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        gev_pkg::REG_DEADZONE: deadzone_r <= cfg_wdata[6:0];
        gev_pkg::REG_DELAY:    delay_r    <= cfg_wdata[15:0];
        gev_pkg::REG_PERIOD:   period_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gev_pkg::REG_DEADZONE: cfg_rdata = {25'd0, deadzone_r};
      gev_pkg::REG_DELAY:    cfg_rdata = {16'd0, delay_r};
      gev_pkg::REG_PERIOD:   cfg_rdata = {16'd0, period_r};
      default:               cfg_rdata = '0;
    endcase
  end

  // item capture; a neutral sample is kept as an all-zero word
  assign neutral_in = !in_pad_connected || ((in_button_word & gev_pkg::NEUTRAL_BIT) != '0);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r     <= gev_pkg::cmd_t'(in_cmd);
      word_r    <= neutral_in ? '0 : in_button_word;
      neutral_r <= neutral_in;
      sx_r      <= in_stick_x;
      sy_r      <= in_stick_y;
      time_r    <= in_time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_idx_r <= '0;
      pop_hit_r <= 1'b0;
    end else begin
      if (ctl.capture) begin
        btn_idx_r <= '0;
        pop_hit_r <= 1'b0;
      end else if (ctl.btn_step) begin
        btn_idx_r <= btn_idx_r + 1'b1;
      end
      if (ctl.pop_step) begin
        pop_hit_r <= (rd_ptr_r != wr_ptr_r);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      held[i] = (word_r & gev_pkg::BUTTON_MASK[i]) != '0;
    end
  end

  // stick direction: dominant axis, must lie past the deadzone
  always_comb begin
    hs = (sx_r >= gev_pkg::STICK_CENTER) ? sx_r - gev_pkg::STICK_CENTER
                                         : gev_pkg::STICK_CENTER - sx_r;
    vs = (sy_r >= gev_pkg::STICK_CENTER) ? sy_r - gev_pkg::STICK_CENTER
                                         : gev_pkg::STICK_CENTER - sy_r;
    dz = {1'b0, deadzone_r};
    st_valid = 1'b0;
    st_code  = 2'd0;
    if (!(hs < dz && vs < dz)) begin
      if (hs > vs) begin
        if (hs > dz) begin
          st_valid = 1'b1;
          st_code  = (sx_r < gev_pkg::STICK_CENTER) ? 2'd2 : 2'd3;
        end
      end else if (vs > dz) begin
        st_valid = 1'b1;
        st_code  = (sy_r < gev_pkg::STICK_CENTER) ? 2'd0 : 2'd1;
      end
    end
  end

  always_comb begin
    nd_valid = 1'b1;
    nd_code  = 2'd0;
    if ((word_r & gev_pkg::DPAD_UP) != '0) begin
      nd_code = 2'd0;
    end else if ((word_r & gev_pkg::DPAD_DOWN) != '0) begin
      nd_code = 2'd1;
    end else if ((word_r & gev_pkg::DPAD_LEFT) != '0) begin
      nd_code = 2'd2;
    end else if ((word_r & gev_pkg::DPAD_RIGHT) != '0) begin
      nd_code = 2'd3;
    end else if (neutral_r) begin
      nd_valid = 1'b0;
    end else begin
      nd_valid = st_valid;
      nd_code  = st_code;
    end
  end

  assign dir_change = (nd_valid != dir_active_r) || (nd_valid && (nd_code != dir_code_r));
  // deadline reached when the wrapped difference is not negative
  assign due_diff   = time_r - deadline_r;
  assign rep_due    = !due_diff[31];

  always_comb begin
    push_en    = 1'b0;
    push_entry = '0;
    if (ctl.btn_step) begin
      push_en    = held[btn_idx_r] ^ latch_r[btn_idx_r];
      push_entry = {1'b0, btn_idx_r, held[btn_idx_r]};
    end else if (ctl.dir_rel) begin
      push_en    = dir_active_r;
      push_entry = {gev_pkg::ACT_UP | {2'b00, dir_code_r}, 1'b0};
    end else if (ctl.dir_set) begin
      push_en    = nd_valid;
      push_entry = {gev_pkg::ACT_UP | {2'b00, nd_code}, 1'b1};
    end else if (ctl.rep_step) begin
      push_en    = dir_active_r && rep_due;
      push_entry = {gev_pkg::ACT_UP | {2'b00, dir_code_r}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r      <= '0;
      dir_active_r <= 1'b0;
      dir_code_r   <= '0;
      deadline_r   <= '0;
    end else begin
      if (ctl.btn_step) begin
        latch_r[btn_idx_r] <= held[btn_idx_r];
      end
      if (ctl.dir_set) begin
        dir_active_r <= nd_valid;
        dir_code_r   <= nd_valid ? nd_code : 2'd0;
        deadline_r   <= nd_valid ? time_r + {16'd0, delay_r} : '0;
      end else if (ctl.rep_step && dir_active_r && rep_due) begin
        deadline_r <= time_r + {16'd0, period_r};
      end
    end
  end

  // ring pointers; a transfer into a full ring drops the oldest entry
  assign wr_next = gev_pkg::ring_next(wr_ptr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else if (push_en) begin
      wr_ptr_r <= wr_next;
      if (wr_next == rd_ptr_r) begin
        rd_ptr_r <= gev_pkg::ring_next(rd_ptr_r);
      end
    end else if (ctl.pop_step && (rd_ptr_r != wr_ptr_r)) begin
      rd_ptr_r <= gev_pkg::ring_next(rd_ptr_r);
    end
  end

  // popped entry is held until the result register loads
  always_ff @(posedge clk) begin
    if (push_en) begin
      ring[wr_ptr_r] <= push_entry;
    end
    if (ctl.pop_step) begin
      mem_q_r <= ring[rd_ptr_r];
    end
  end

  always_comb begin
    if (wr_ptr_r >= rd_ptr_r) begin
      lvl = gev_pkg::LVL_W'(wr_ptr_r) - gev_pkg::LVL_W'(rd_ptr_r);
    end else begin
      lvl = gev_pkg::LVL_W'(wr_ptr_r) + gev_pkg::LVL_W'(gev_pkg::QUEUE_DEPTH)
          - gev_pkg::LVL_W'(rd_ptr_r);
    end
    lvl_ext = gev_pkg::CNT_W'(lvl);
    lvl_sat = (lvl_ext > gev_pkg::CNT_W'(63)) ? 6'd63 : lvl_ext[5:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_event_valid    <= pop_hit_r;
      out_event_action   <= pop_hit_r ? mem_q_r[4:1] : 4'd0;
      out_event_pressed  <= pop_hit_r ? mem_q_r[0] : 1'b0;
      out_held_buttons   <= latch_r;
      out_direction_held <= dir_active_r;
      out_held_direction <= dir_code_r;
      out_queue_count    <= lvl_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign sts.item_cmd   = cmd_r;
  assign sts.btn_last   = (btn_idx_r == 3'd7);
  assign sts.dir_change = dir_change;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

`default_nettype wire

>>> rtl/gev_checker.sv
// port-level checks for gamepad_event_generator_top, attached by bind
// depends on gamepad_event_generator_top_assert.svh
`default_nettype none
`include "gamepad_event_generator_top_assert.svh"

module gev_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       out_event_valid,
  input wire [3:0] out_event_action,
  input wire       out_event_pressed,
  input wire       out_direction_held,
  input wire [1:0] out_held_direction
);

  wire [4:0] evt_fields = {out_event_action, out_event_pressed};
  wire       evt_shape_ok = (out_event_valid && out_event_action <= 4'd11) ||
    (!out_event_valid && out_event_action == 4'd0 && !out_event_pressed);

  // a result waiting for transfer keeps its event fields
  `GEV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(evt_fields))

  // one item at a time: no back-to-back input transfer
  `GEV_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

  // a missing event carries zero fields, a present one a mapped action
  `GEV_ASSERT_NOW(a_event_fields, out_valid, evt_shape_ok)

  // no held direction reads as code zero
  `GEV_ASSERT_NOW(a_dir_idle, out_valid && !out_direction_held, out_held_direction == 2'd0)

endmodule

bind gamepad_event_generator_top gev_checker u_gev_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_event_valid    (out_event_valid),
  .out_event_action   (out_event_action),
  .out_event_pressed  (out_event_pressed),
  .out_direction_held (out_direction_held),
  .out_held_direction (out_held_direction)
);

`default_nettype wire
